[rtl/sfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and constants of the status frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int FRAME_BUF_LEN_DEF = 20;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [7:0] HDR_BYTE        = 8'hFF;
    localparam int         HDR_LEN         = 5;
    localparam int         RANGE_MIN_LEN   = 5;
    localparam int         VERSION_MIN_LEN = 7;

    // only payload bytes 0..8 (frame bytes 5..13) are ever decoded
    localparam int         STORE_SLOTS     = 9;

    localparam int         TDATA_IN_W      = 8;
    localparam int         TDATA_OUT_W     = 88;
    localparam int         RESULT_W        = 81;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_CSUM    = 2'd1,
        STATUS_BAD_LEN = 2'd2,
        STATUS_OVERRUN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_GOOD  = 2'd1,
        CMD_ERROR = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [3:0]  slot;
        logic [7:0]  data;
        status_t     status;
        logic [4:0]  len;
        logic        range_valid;
        logic        version_valid;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/sfp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_front
// Byte classifier: header search, length check, running checksum.
// ----------------------------------------------------------------------------
module sfp_front #(
    parameter int FRAME_BUF_LEN = sfp_pkg::FRAME_BUF_LEN_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [7:0]   cfg_wdata,
    input  wire logic         byte_valid,
    input  wire logic [7:0]   rx_byte,
    output sfp_pkg::cmd_t     cmd,
    output logic              cmd_push
);

    localparam int LW = $clog2(FRAME_BUF_LEN);

    typedef enum logic [6:0] {
        ST_HDR1    = 7'b0000001,
        ST_HDR2    = 7'b0000010,
        ST_TYPE    = 7'b0000100,
        ST_LEN_HI  = 7'b0001000,
        ST_LEN_LO  = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_CHECK   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    type_reg;
    logic [7:0]    len_high_reg, len_high_next;
    logic [LW-1:0] len_held_reg, len_held_next;
    logic [LW-1:0] count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   len_full;
    logic          overrun;

    assign len_full = {len_high_reg, rx_byte};
    assign overrun  = ((LW+1)'(count_reg) + (LW+1)'(sfp_pkg::HDR_LEN))
                      >= (LW+1)'(FRAME_BUF_LEN);

    always_comb
    begin
        state_next    = state_reg;
        len_high_next = len_high_reg;
        len_held_next = len_held_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        cmd_push      = 1'b0;
        cmd.op            = sfp_pkg::CMD_STORE;
        cmd.slot          = count_reg[3:0];
        cmd.data          = rx_byte;
        cmd.status        = sfp_pkg::STATUS_GOOD;
        cmd.len           = 5'(len_held_reg);
        cmd.range_valid   = len_held_reg > LW'(sfp_pkg::RANGE_MIN_LEN);
        cmd.version_valid = len_held_reg > LW'(sfp_pkg::VERSION_MIN_LEN);
        if (byte_valid)
        begin
            case (state_reg)
                ST_HDR1:
                begin
                    sum_next   = rx_byte;
                    state_next = (rx_byte == sfp_pkg::HDR_BYTE) ? ST_HDR2 : ST_HDR1;
                end
                ST_HDR2:
                begin
                    sum_next   = sum_reg + rx_byte;
                    state_next = (rx_byte == sfp_pkg::HDR_BYTE) ? ST_TYPE : ST_HDR1;
                end
                ST_TYPE:
                begin
                    sum_next   = sum_reg + rx_byte;
                    state_next = (rx_byte == type_reg) ? ST_LEN_HI : ST_HDR1;
                end
                ST_LEN_HI:
                begin
                    sum_next      = sum_reg + rx_byte;
                    len_high_next = rx_byte;
                    state_next    = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = '0;
                    if (len_full >= 16'(FRAME_BUF_LEN))
                    begin
                        state_next = ST_HDR1;
                        cmd_push   = 1'b1;
                        cmd.op     = sfp_pkg::CMD_ERROR;
                        cmd.status = sfp_pkg::STATUS_BAD_LEN;
                        cmd.len    = '0;
                    end
                    else
                    begin
                        len_held_next = LW'(rx_byte);
                        state_next    = (rx_byte != 8'd0) ? ST_PAYLOAD : ST_CHECK;
                    end
                end
                ST_PAYLOAD:
                begin
                    if (overrun)
                    begin
                        state_next = ST_HDR1;
                        cmd_push   = 1'b1;
                        cmd.op     = sfp_pkg::CMD_ERROR;
                        cmd.status = sfp_pkg::STATUS_OVERRUN;
                    end
                    else
                    begin
                        sum_next   = sum_reg + rx_byte;
                        count_next = count_reg + LW'(1);
                        // bytes past the decoded window need no store write
                        cmd_push   = count_reg < LW'(sfp_pkg::STORE_SLOTS);
                        if (count_next >= len_held_reg)
                            state_next = ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_next = ST_HDR1;
                    cmd_push   = 1'b1;
                    if (rx_byte != ~sum_reg)
                    begin
                        cmd.op     = sfp_pkg::CMD_ERROR;
                        cmd.status = sfp_pkg::STATUS_CSUM;
                    end
                    else
                        cmd.op     = sfp_pkg::CMD_GOOD;
                end
                default:
                    state_next = ST_HDR1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HDR1;
            type_reg     <= 8'd1;
            len_high_reg <= '0;
            len_held_reg <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_high_reg <= len_high_next;
            len_held_reg <= len_held_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            if (cfg_we)
                type_reg <= cfg_wdata;
        end
    end

`ifndef SYNTH
    a_good_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd.op == sfp_pkg::CMD_GOOD) |-> (state_reg == ST_CHECK))
        else $error("good frame request outside checksum phase");
`endif

endmodule
`default_nettype wire

[rtl/sfp_cmd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_cmd_fifo
// Short request queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module sfp_cmd_fifo #(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  sfp_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output sfp_pkg::cmd_t      head_cmd,
    output logic               not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfp_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");
`endif

endmodule
`default_nettype wire

[rtl/sfp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_back
// Executor: frame store writes and the result output register.
// ----------------------------------------------------------------------------
module sfp_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  sfp_pkg::cmd_t                            head_cmd,
    input  wire logic                                head_valid,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [sfp_pkg::TDATA_OUT_W-1:0]          m_tdata
);

    logic [7:0]                     store_reg [sfp_pkg::STORE_SLOTS];
    logic                           out_valid_reg;
    logic [sfp_pkg::RESULT_W-1:0]   out_data_reg;
    logic [sfp_pkg::RESULT_W-1:0]   result;
    logic                           out_free;
    logic                           is_good;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = head_valid && ((head_cmd.op == sfp_pkg::CMD_STORE) || out_free);
    assign is_good  = (head_cmd.op == sfp_pkg::CMD_GOOD);

    // store slot k holds frame byte 5 + k
    always_comb
    begin
        result = '0;
        result[1:0] = head_cmd.status;
        result[6:2] = head_cmd.len;
        if (is_good)
        begin
            result[22:7]  = {store_reg[1], store_reg[0]};
            result[38:23] = {store_reg[3], store_reg[2]};
            result[46:39] = store_reg[4];
            result[47]    = head_cmd.range_valid;
            if (head_cmd.range_valid)
                result[63:48] = {store_reg[6], store_reg[5]};
            result[64]    = head_cmd.version_valid;
            if (head_cmd.version_valid)
            begin
                result[72:65] = store_reg[8];
                result[80:73] = store_reg[7];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sfp_pkg::STORE_SLOTS; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            if (pop && head_cmd.op == sfp_pkg::CMD_STORE)
            begin
                for (int i = 0; i < sfp_pkg::STORE_SLOTS; i++)
                begin
                    if (head_cmd.slot == 4'(i))
                        store_reg[i] <= head_cmd.data;
                end
            end
            if (pop && head_cmd.op != sfp_pkg::CMD_STORE)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.op != sfp_pkg::CMD_STORE)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(sfp_pkg::TDATA_OUT_W - sfp_pkg::RESULT_W)'(0), out_data_reg};

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != sfp_pkg::STATUS_GOOD)
            |-> (m_tdata[80:7] == '0))
        else $error("error result carries decoded fields");
`endif

endmodule
`default_nettype wire

[rtl/status_frame_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// status_frame_parser_top
// Status frame parser: classifier, request queue and executor.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the request queue has room, set by the classifier fsm
// path: a closing byte's request is written into the request queue, then popped into the output register
// the request queue absorbs output stalls; s_tready drops only when it is full
// reset (rst_n, async low): header search, store zeroed, queue and output
// emptied, expected_type back to 1
module status_frame_parser_top #(
    parameter int FRAME_BUF_LEN = sfp_pkg::FRAME_BUF_LEN_DEF,
    parameter int QUEUE_DEPTH   = sfp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [7:0]                         cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] rx_byte
    input  wire logic [sfp_pkg::TDATA_IN_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [1:0] status, [6:2] payload_len, [22:7] samples_per_scan,
    // [38:23] scan_period, [46:39] flags, [47] range_valid, [63:48] range_mm,
    // [64] version_valid, [72:65] fw_major, [80:73] fw_minor, rest zero
    output logic [sfp_pkg::TDATA_OUT_W-1:0]         m_tdata
);

    sfp_pkg::cmd_t front_cmd, head_cmd;
    logic          front_push, q_full, q_pop, q_not_empty;

    assign s_tready = !q_full;

    sfp_front #(
        .FRAME_BUF_LEN (FRAME_BUF_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (s_tvalid && s_tready),
        .rx_byte    (s_tdata),
        .cmd        (front_cmd),
        .cmd_push   (front_push)
    );

    sfp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty)
    );

    sfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire
